[rtl/core/radix_conversion_digit_stack_macros.svh]
// Assertion macros shared by the radix conversion block.
// Depends on nothing; taken in by the top level with `include.
`ifndef RADIX_CONVERSION_DIGIT_STACK_MACROS_SVH
`define RADIX_CONVERSION_DIGIT_STACK_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset
`define RDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante, outside reset
`define RDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rdc_pkg.sv]
// Shared types and constants for the radix conversion block.
// Depends on nothing; used by rdc_ctrl, rdc_dpath and the top level.
package rdc_pkg;

  // Field widths of the ports
  localparam int VALUE_BITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int DIGIT_W     = 6;

  // Working width of the value (2 to 32) and depth of the digit stack
  localparam int VALUE_WIDTH = 32;
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Remainder estimate stays below twice the radix, so 7 bits carry it
  localparam int REM_W       = 7;
  localparam int RADIX_CODES = 2 ** RADIX_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POP
  } rdc_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic pop;
  } rdc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic quo_zero;
    logic cnt_one;
  } rdc_status_t;

endpackage

[rtl/core/rdc_ctrl.sv]
// Sequencer for the radix conversion block: load, divide loop, pop loop.
// Depends on rdc_pkg for the state type and the command/status structs.
module rdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rdc_pkg::rdc_status_t status,
  output rdc_pkg::rdc_cmd_t   cmd,
  output logic                busy
);

  rdc_pkg::rdc_state_t state, state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through multiply and divide per digit, then pop the stack empty
  always_comb begin
    state_next = state;
    unique case (state)
      rdc_pkg::ST_IDLE: begin
        if (start) state_next = rdc_pkg::ST_MUL;
      end
      rdc_pkg::ST_MUL: state_next = rdc_pkg::ST_DIV;
      rdc_pkg::ST_DIV: begin
        if (status.quo_zero) state_next = rdc_pkg::ST_POP;
        else state_next = rdc_pkg::ST_MUL;
      end
      rdc_pkg::ST_POP: begin
        if (status.cnt_one) state_next = rdc_pkg::ST_IDLE;
      end
      default: state_next = rdc_pkg::ST_IDLE;
    endcase
  end

  // Drive the datapath commands and the busy flag
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      rdc_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      rdc_pkg::ST_MUL: cmd.mul = 1'b1;
      rdc_pkg::ST_DIV: cmd.div = 1'b1;
      rdc_pkg::ST_POP: cmd.pop = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule

[rtl/core/rdc_dpath.sv]
// Datapath: radix register, reciprocal divider, digit stack and output register.
// Depends on rdc_pkg for widths, constants and the command/status structs.
module rdc_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0]   cfg_wdata,
  input  logic [rdc_pkg::VALUE_BITS-1:0] value,
  input  rdc_pkg::rdc_cmd_t             cmd,
  output rdc_pkg::rdc_status_t          status,
  output logic                          strobe,
  output logic [rdc_pkg::DIGIT_W-1:0]   digit,
  output logic                          last
);

  localparam int VW = rdc_pkg::VALUE_WIDTH;
  localparam int RW = rdc_pkg::RADIX_W;
  localparam int MW = RW + rdc_pkg::REM_W;

  logic [RW-1:0]                 radix;
  logic [RW-1:0]                 rdx;
  logic [RW-1:0]                 rdx_clamped;
  logic [VW-1:0]                 recip;
  logic [VW-1:0]                 n;
  logic [2*VW-1:0]               prod;
  logic [rdc_pkg::CNT_W-1:0]     count;
  logic [rdc_pkg::DIGIT_W-1:0]   stack_mem [rdc_pkg::STACK_DEPTH];
  logic [VW-1:0]                 recip_tab [rdc_pkg::RADIX_CODES];

  logic [VW-1:0]                 q_est;
  logic [MW-1:0]                 qr_lo;
  logic [rdc_pkg::REM_W-1:0]     rem_est;
  logic                          rem_fix;
  logic [rdc_pkg::REM_W-1:0]     rem;
  logic [VW-1:0]                 quo;
  logic [rdc_pkg::CNT_W-1:0]     count_dec;

  // Build floor(2^VW / r) for every radix code from 2 up at elaboration; codes 0 and 1 get zero
  for (genvar gi = 0; gi < rdc_pkg::RADIX_CODES; gi++) begin : g_recip
    localparam logic [VW-1:0] RecipVal =
      (gi < 2) ? '0 : VW'(((2 * VW)'(1) << VW) / gi);
    assign recip_tab[gi] = RecipVal;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  // Clamp the radix into the legal range
  always_comb begin
    priority if (radix < rdc_pkg::RADIX_MIN) rdx_clamped = rdc_pkg::RADIX_MIN;
    else if (radix > rdc_pkg::RADIX_MAX) rdx_clamped = rdc_pkg::RADIX_MAX;
    else rdx_clamped = radix;
  end

  // Quotient estimate is low by at most one; fix it with one compare and subtract
  always_comb begin
    q_est   = prod[2*VW-1:VW];
    qr_lo   = MW'(q_est[rdc_pkg::REM_W-1:0]) * MW'(rdx);
    rem_est = n[rdc_pkg::REM_W-1:0] - qr_lo[rdc_pkg::REM_W-1:0];
    rem_fix = (rem_est >= rdc_pkg::REM_W'(rdx));
    rem     = rem_fix ? (rem_est - rdc_pkg::REM_W'(rdx)) : rem_est;
    quo     = q_est + VW'(rem_fix);
  end

  assign count_dec       = count - rdc_pkg::CNT_W'(1);
  assign status.quo_zero = (quo == '0);
  assign status.cnt_one  = (count == rdc_pkg::CNT_W'(1));

  // Operand registers: load the item, then multiply and divide per digit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n     <= value[VW-1:0];
      rdx   <= rdx_clamped;
      recip <= recip_tab[rdx_clamped];
    end else if (cmd.div) begin
      n <= quo;
    end
    if (cmd.mul) begin
      prod <= (2 * VW)'(n) * (2 * VW)'(recip);
    end
  end

  // Stack fill count: clear on load, count pushes up and pops down
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.div && count < rdc_pkg::CNT_W'(rdc_pkg::STACK_DEPTH)) begin
      count <= count + rdc_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count <= count_dec;
    end
  end

  // Digit stack memory: push remainders, pop into the registered read port
  always_ff @(posedge clk) begin
    if (cmd.div && count < rdc_pkg::CNT_W'(rdc_pkg::STACK_DEPTH)) begin
      stack_mem[count[rdc_pkg::IDX_W-1:0]] <= rem[rdc_pkg::DIGIT_W-1:0];
    end
    if (cmd.pop) begin
      digit <= stack_mem[count_dec[rdc_pkg::IDX_W-1:0]];
      last  <= (count == rdc_pkg::CNT_W'(1));
    end
  end

  // Result strobe is registered from each pop, so it rises in the cycle after it
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.pop;
    end
  end

endmodule

[rtl/core/radix_conversion_digit_stack.sv]
// Top level of the radix conversion block: controller plus datapath.
// Depends on rdc_pkg, rdc_ctrl, rdc_dpath and the assertion macro header.
//
// Use: pulse start with value while busy is low; the value is transferred at
// that edge and converted into digits of the current radix. Digits come out
// most significant first on digit, each for one cycle with strobe high; the
// final, least significant digit also has last high. A zero value gives the
// single digit 0. The radix is written through cfg_we/cfg_wdata while the
// block is idle; codes below 2 act as 2, codes above 36 as 36.
// Sequence: for each digit one multiply step and one divide-correct step,
// then one stack pop per digit, all while busy is high. The last digit
// strobes in the cycle that busy falls, so the next item may be transferred
// there. The per-digit recurrence through the reciprocal multiplier sets
// the divide phase; the single-port stack read sets the pop phase.
// Reset clears the controller, the stack count and the strobe, and sets the
// radix to 10. The receiver cannot stall; every strobe is a transfer.
`include "radix_conversion_digit_stack_macros.svh"

module radix_conversion_digit_stack (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [rdc_pkg::VALUE_BITS-1:0] value,
  input  logic                           cfg_we,
  input  logic [rdc_pkg::RADIX_W-1:0]    cfg_wdata,
  output logic                           strobe,
  output logic [rdc_pkg::DIGIT_W-1:0]    digit,
  output logic                           last
);

  rdc_pkg::rdc_cmd_t    cmd;
  rdc_pkg::rdc_status_t status;

  // Sequencer
  rdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Arithmetic, stack and result register
  rdc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .digit     (digit),
    .last      (last)
  );

  // A transferred item always makes the block busy in the next cycle
  `RDC_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "no busy after transfer")

  // Digits only come from pops made while busy
  `RDC_ASSERT_SAME(a_strobe_busy, clk, rst, strobe, $past(busy), "strobe without work")

  // The final digit ends the run; nothing follows straight after it
  `RDC_ASSERT_NEXT(a_last_end, clk, rst, strobe && last, !strobe, "digit after last")

  // The final digit coincides with the block going idle
  `RDC_ASSERT_SAME(a_last_idle, clk, rst, strobe && last, !busy, "busy after last digit")

endmodule

[tb/testbench.sv]
// Self-checking testbench for radix_conversion_digit_stack: directed table, then random bursts.
// Depends on rdc_pkg and the RTL of the block; digits not typed in the plan come from its own model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEXT_W = 8 * rdc_pkg::STACK_DEPTH;
  localparam logic [TEXT_W-1:0] NO_TEXT = '0;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 28;
  localparam int PLAN_ROWS = 30;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [rdc_pkg::DIGIT_W-1:0] digit;
    logic                        last;
  } digit_t;

  // One row of the directed plan: a radix write, or a value with optional expected text
  typedef struct packed {
    logic                           is_cfg;
    logic [rdc_pkg::RADIX_W-1:0]    code;
    logic [rdc_pkg::VALUE_BITS-1:0] operand;
    logic [TEXT_W-1:0]              text;
  } plan_row_t;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [rdc_pkg::VALUE_BITS-1:0] value;
  logic                           cfg_we;
  logic [rdc_pkg::RADIX_W-1:0]    cfg_wdata;
  logic                           strobe;
  logic [rdc_pkg::DIGIT_W-1:0]    digit;
  logic                           last;

  logic [rdc_pkg::RADIX_W-1:0] radix_code;
  digit_t                      digits_due [$];
  digit_t                      head;
  int                          mismatches;

  // Expected text is written in digits of the current radix, a to z for 10 to 35, most significant digit first
  plan_row_t plan [PLAN_ROWS] = '{
    '{1'b0, 6'd0,  32'd0,          "0"},
    '{1'b0, 6'd0,  32'hFFFF_FFFF,  "4294967295"},
    '{1'b0, 6'd0,  32'd9,          "9"},
    '{1'b0, 6'd0,  32'd10,         "10"},
    '{1'b1, 6'd2,  32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'hFFFF_FFFF,  "11111111111111111111111111111111"},
    '{1'b0, 6'd0,  32'd1,          "1"},
    '{1'b0, 6'd0,  32'h8000_0000,  "10000000000000000000000000000000"},
    '{1'b1, 6'd36, 32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'hFFFF_FFFF,  "1z141z3"},
    '{1'b0, 6'd0,  32'd35,         "z"},
    '{1'b0, 6'd0,  32'd36,         "10"},
    '{1'b1, 6'd0,  32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'd5,          "101"},
    '{1'b1, 6'd1,  32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'd6,          "110"},
    '{1'b1, 6'd37, 32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'd71,         "1z"},
    '{1'b1, 6'd63, 32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'd0,          "0"},
    '{1'b0, 6'd0,  32'd72,         "20"},
    '{1'b1, 6'd16, 32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'hDEAD_BEEF,  "deadbeef"},
    '{1'b0, 6'd0,  32'h0000_FFFF,  NO_TEXT},
    '{1'b1, 6'd7,  32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'd12345,      NO_TEXT},
    '{1'b0, 6'd0,  32'h2A5A_5A5A,  NO_TEXT},
    '{1'b1, 6'd3,  32'd0,          NO_TEXT},
    '{1'b0, 6'd0,  32'hFFFF_FFFF,  NO_TEXT},
    '{1'b0, 6'd0,  32'h5555_5555,  NO_TEXT}
  };

  radix_conversion_digit_stack DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .strobe    (strobe),
    .digit     (digit),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Divide repeatedly by the clamped radix, stack the remainders, queue them top first
  function automatic void predict_digits(input logic [rdc_pkg::VALUE_BITS-1:0] operand);
    logic [rdc_pkg::DIGIT_W-1:0] stack [rdc_pkg::STACK_DEPTH];
    logic [63:0]                 rest;
    logic [63:0]                 base;
    int                          depth;
    rest = 64'(operand) & ((64'd2 << (rdc_pkg::VALUE_WIDTH - 1)) - 64'd1);
    if (radix_code < rdc_pkg::RADIX_MIN)
      base = 64'(rdc_pkg::RADIX_MIN);
    else if (radix_code > rdc_pkg::RADIX_MAX)
      base = 64'(rdc_pkg::RADIX_MAX);
    else
      base = 64'(radix_code);
    depth = 0;
    do begin
      if (depth < rdc_pkg::STACK_DEPTH) begin
        stack[depth] = rdc_pkg::DIGIT_W'(rest % base);
        depth++;
      end
      rest = rest / base;
    end while (rest != 64'd0);
    for (int i = depth - 1; i >= 0; i--)
      digits_due.push_back('{stack[i], i == 0});
  endfunction

  // Queue the digits spelt out in a typed row; the rightmost character is the last digit
  function automatic void expect_text(input logic [TEXT_W-1:0] text);
    logic [7:0] ch;
    for (int i = rdc_pkg::STACK_DEPTH - 1; i >= 0; i--) begin
      ch = text[8*i +: 8];
      if (ch != 8'd0)
        digits_due.push_back('{(ch >= "a") ? rdc_pkg::DIGIT_W'(ch - "a" + 8'd10)
                                           : rdc_pkg::DIGIT_W'(ch - "0"),
                               i == 0});
    end
  endfunction

  function automatic logic [rdc_pkg::VALUE_BITS-1:0] random_operand();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return $urandom() >> $urandom_range(0, rdc_pkg::VALUE_BITS - 1);
      default:    return $urandom();
    endcase
  endfunction

  // Offer one value and hold it until the transfer; start stays high for the caller
  task automatic convert(input logic [rdc_pkg::VALUE_BITS-1:0] operand,
                         input logic [TEXT_W-1:0] text);
    start <= 1'b1;
    value <= operand;
    do @(posedge clk); while (busy);
    if (text != NO_TEXT)
      expect_text(text);
    else
      predict_digits(operand);
  endtask

  // Stop offering and wait until every expected digit has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    while (digits_due.size() != 0 || busy)
      @(posedge clk);
  endtask

  task automatic write_radix(input logic [rdc_pkg::RADIX_W-1:0] code);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    radix_code = code;
    cfg_we    <= 1'b0;
  endtask

  // Compare every strobed digit with the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (digits_due.size() == 0) begin
        $display("%0t: digit with none expected: expected nothing, actual digit %0d last %0b",
                 $time, digit, last);
        mismatches++;
      end else begin
        head = digits_due.pop_front();
        if (digit !== head.digit) begin
          $display("%0t: digit mismatch: expected %0d, actual %0d", $time, head.digit, digit);
          mismatches++;
        end
        if (last !== head.last) begin
          $display("%0t: last mismatch: expected %0b, actual %0b", $time, head.last, last);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: directed plan, then random phases of bursts at varied radices
  initial begin
    int left;
    int burst;
    int gap;
    int waited;
    mismatches = 0;
    radix_code = rdc_pkg::RADIX_RESET;
    rst       <= 1'b1;
    start     <= 1'b0;
    value     <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed plan back to back
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].is_cfg)
        write_radix(plan[r].code);
      else
        convert(plan[r].operand, plan[r].text);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_radix(rdc_pkg::RADIX_MIN);
        1:       write_radix(rdc_pkg::RADIX_MAX);
        2:       write_radix('0);
        3:       write_radix('1);
        default: write_radix(rdc_pkg::RADIX_W'($urandom_range(0, rdc_pkg::RADIX_CODES - 1)));
      endcase
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 8);
        while (burst > 0 && left > 0) begin
          convert(random_operand(), NO_TEXT);
          burst--;
          left--;
        end
        // Idle between bursts, sometimes not at all
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Wait for the remaining digits, then let any stray strobe show up
    start <= 1'b0;
    waited = 0;
    while (digits_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (digits_due.size() != 0) begin
      $display("%0t: missing digits: expected %0d more, actual 0", $time, digits_due.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
